### src/stpivot_pkg.sv
// Shared constants, widths and codes for the simplex tableau pivot block.
package stpivot_pkg;

  localparam int MAX_ROWS  = 16;
  localparam int MAX_VARS  = 32;
  localparam int FRAC_BITS = 16;
  localparam int NCOLS     = MAX_VARS + 1;

  localparam int DATA_W = 32;
  localparam int ROW_W  = $clog2(MAX_ROWS);
  localparam int RCNT_W = $clog2(MAX_ROWS + 1);
  localparam int COL_W  = $clog2(NCOLS);
  localparam int CCNT_W = $clog2(NCOLS + 1);
  localparam int QUO_W  = DATA_W + FRAC_BITS;
  localparam int DCNT_W = $clog2(QUO_W + 1);
  localparam int PROD_W = 2 * DATA_W;
  localparam int SUM_W  = 2 * DATA_W - FRAC_BITS + 2;

  // Stream field layout
  localparam int ACT_W       = 3;
  localparam int ROW_F_W     = 4;
  localparam int COL_F_W     = 6;
  localparam int VAL_W       = 32;
  localparam int STAT_W      = 2;
  localparam int IN_TDATA_W  = 48;
  localparam int OUT_TDATA_W = 48;
  localparam int IN_COL_LSB  = ROW_F_W;
  localparam int IN_VAL_LSB  = ROW_F_W + COL_F_W;
  localparam int OUT_PAD_W   = OUT_TDATA_W - VAL_W - 2 * COL_F_W - STAT_W;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 6;
  localparam int AROWS_W    = 5;
  localparam int AVARS_W    = 6;

  localparam logic signed [DATA_W-1:0] Q_MAX = {1'b0, {(DATA_W-1){1'b1}}};
  localparam logic signed [DATA_W-1:0] Q_MIN = {1'b1, {(DATA_W-1){1'b0}}};
  localparam logic [DATA_W-1:0]        Q_ONE = DATA_W'(1) << FRAC_BITS;

  typedef enum logic [ACT_W-1:0] {
    ACT_LOAD_ROW  = 3'd0,
    ACT_LOAD_OBJ  = 3'd1,
    ACT_SET_BASIS = 3'd2,
    ACT_PIVOT     = 3'd3,
    ACT_READ_ROW  = 3'd4,
    ACT_READ_OBJ  = 3'd5
  } action_t;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK        = 2'd0,
    STAT_UNBOUNDED = 2'd1,
    STAT_SATURATED = 2'd2
  } status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_INT_RATIO   = 2'd0,
    CFG_ACTIVE_ROWS = 2'd1,
    CFG_ACTIVE_VARS = 2'd2
  } cfg_idx_t;

endpackage

### src/simplex_tableau_pivot.sv
// Slack-form simplex tableau held in block memory, with an iterative pivot engine.
// A pivot runs a ratio test over the active rows, divides out the pivot row column by
// column, updates each other row and then the objective, and scans for the next
// entering column; the radix-2 divider (one quotient bit a cycle) sets most of its
// run time. One item at a time.
// Reset clears control and configuration, not the tableau.
module simplex_tableau_pivot (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_tvalid,
  output logic                                  in_tready,
  // row, column, value (low bits first), upper bits unused
  input  logic [stpivot_pkg::IN_TDATA_W-1:0]    in_tdata,
  // action
  input  logic [stpivot_pkg::ACT_W-1:0]         in_tuser,
  output logic                                  out_tvalid,
  input  logic                                  out_tready,
  // read_value, leaving_var, next_entering, status (low bits first), zero pad
  output logic [stpivot_pkg::OUT_TDATA_W-1:0]   out_tdata,
  input  logic                                  cfg_wr_en,
  input  logic [stpivot_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [stpivot_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import stpivot_pkg::*;

  typedef enum logic [14:0] {
    S_IDLE     = 15'b000000000000001,
    S_RD       = 15'b000000000000010,
    S_RT_RD    = 15'b000000000000100,
    S_RT_CHK   = 15'b000000000001000,
    S_RT_DIV   = 15'b000000000010000,
    S_HAT_RD   = 15'b000000000100000,
    S_HAT_CHK  = 15'b000000001000000,
    S_HAT_DIV  = 15'b000000010000000,
    S_UPD_AE   = 15'b000000100000000,
    S_LOAD_K   = 15'b000001000000000,
    S_OBJ_CE   = 15'b000010000000000,
    S_STREAM   = 15'b000100000000000,
    S_SCAN0    = 15'b001000000000000,
    S_SCAN     = 15'b010000000000000,
    S_DONE     = 15'b100000000000000
  } state_t;

  state_t state_r;

  // Memories
  logic signed [DATA_W-1:0] tab_mem [MAX_ROWS][NCOLS];
  logic signed [DATA_W-1:0] obj_mem [NCOLS];
  logic        [COL_F_W-1:0] basis_r [MAX_ROWS];

  logic signed [DATA_W-1:0] tab_a_q_r, tab_b_q_r, obj_q_r;
  logic [ROW_W-1:0] a_row, b_row, w_row;
  logic [COL_W-1:0] a_col, b_col, w_col, o_col, ow_col;
  logic             tab_we, obj_we;
  logic signed [DATA_W-1:0] w_data, ow_data;

  // Configuration
  logic               int_ratio_r;
  logic [AROWS_W-1:0] act_rows_r;
  logic [AVARS_W-1:0] act_vars_r;
  logic [RCNT_W-1:0]  nr;
  logic [CCNT_W-1:0]  nv;

  // Item
  logic [ROW_F_W-1:0] in_row;
  logic [COL_F_W-1:0] in_col;
  logic [VAL_W-1:0]   in_val;
  logic               in_fire, in_col_ok;
  action_t            act_r;
  logic [COL_F_W-1:0] col_r;
  logic               col_ok_r;

  // Pivot
  logic [RCNT_W-1:0]  i_r;
  logic [CCNT_W-1:0]  j_r;
  logic [ROW_W-1:0]   piv_row_r;
  logic signed [DATA_W-1:0] piv_r, cand_r, k_r;
  logic [QUO_W-1:0]   best_r;
  logic               bvalid_r;
  logic [COL_F_W-1:0] lv_col_r;
  logic               lv_r, obj_mode_r, hat_neg_r, sat_r;
  logic [COL_F_W-1:0] basis_l;
  logic               basis_lv;

  // Stream pipeline
  logic               s1v_r, s2v_r;
  logic [CCNT_W-1:0]  s1_col_r, s2_col_r;
  logic signed [PROD_W-1:0] prod_r;
  logic signed [DATA_W-1:0] old_r;
  logic signed [PROD_W-1:0] prod_adj, m_full;
  logic signed [SUM_W-1:0]  m_s, old_s, sum_s;
  logic signed [DATA_W-1:0] upd_val;
  logic                     upd_ovf;

  // Divider
  logic [DATA_W-1:0] div_rem_r, div_den_r, div_rem_sh;
  logic [QUO_W-1:0]  div_num_r;
  logic [DCNT_W-1:0] div_cnt_r;
  logic              div_ge, div_done, div_start;
  logic [QUO_W-1:0]  div_start_num;
  logic [DATA_W-1:0] div_start_den;
  logic [DATA_W-1:0] hat_src, hat_mag;
  logic signed [DATA_W-1:0] hat_val;
  logic              hat_ovf, rt_elig;
  logic [QUO_W-1:0]  q_best;

  // Scan and result
  logic [CCNT_W-1:0]  sc_j_r;
  logic [COL_F_W-1:0] sc_pcol_r;
  logic               sc_pend_r;
  logic [COL_F_W-1:0] nxt_r, leave_r;
  status_t            status_r;
  logic signed [DATA_W-1:0] rdv_r;
  logic               out_tvalid_r;
  logic [OUT_TDATA_W-1:0] out_tdata_r;

  assign in_row    = in_tdata[ROW_F_W-1:0];
  assign in_col    = in_tdata[IN_COL_LSB +: COL_F_W];
  assign in_val    = in_tdata[IN_VAL_LSB +: VAL_W];
  assign in_tready = (state_r == S_IDLE);
  assign in_fire   = in_tvalid && in_tready;
  assign in_col_ok = (32'(in_col) <= MAX_VARS) && (32'(in_row) < MAX_ROWS);

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

  assign nr = (32'(act_rows_r) > MAX_ROWS) ? RCNT_W'(MAX_ROWS) : RCNT_W'(act_rows_r);
  assign nv = (32'(act_vars_r) > MAX_VARS) ? CCNT_W'(MAX_VARS) : CCNT_W'(act_vars_r);

  assign basis_l  = basis_r[piv_row_r];
  assign basis_lv = (basis_l != '0) && (CCNT_W'(basis_l) <= nv) && (basis_l != col_r);

  // Divider step
  assign div_rem_sh = {div_rem_r[DATA_W-2:0], div_num_r[QUO_W-1]};
  assign div_ge     = div_rem_sh >= div_den_r;
  assign div_done   = (div_cnt_r == '0);

  assign rt_elig = (tab_a_q_r > 0) && !tab_b_q_r[DATA_W-1];
  assign hat_src = (lv_r && (CCNT_W'(lv_col_r) == j_r)) ? Q_ONE : tab_a_q_r;
  assign hat_mag = hat_src[DATA_W-1] ? (~hat_src + DATA_W'(1)) : hat_src;
  assign q_best  = int_ratio_r ? {div_num_r[QUO_W-1:FRAC_BITS], {FRAC_BITS{1'b0}}} : div_num_r;

  always_comb begin
    div_start     = 1'b0;
    div_start_num = '0;
    div_start_den = '0;
    if (state_r == S_RT_CHK && rt_elig) begin
      div_start     = 1'b1;
      div_start_num = {tab_b_q_r, {FRAC_BITS{1'b0}}};
      div_start_den = tab_a_q_r;
    end else if (state_r == S_HAT_CHK) begin
      div_start     = 1'b1;
      div_start_num = {hat_mag, {FRAC_BITS{1'b0}}};
      div_start_den = piv_r;
    end
  end

  // Saturate the pivot row quotient
  always_comb begin
    if (!hat_neg_r) begin
      hat_ovf = div_num_r > QUO_W'(Q_MAX);
      hat_val = hat_ovf ? Q_MAX : div_num_r[DATA_W-1:0];
    end else begin
      hat_ovf = div_num_r > {{(QUO_W-DATA_W){1'b0}}, Q_MIN};
      hat_val = hat_ovf ? Q_MIN : (~div_num_r[DATA_W-1:0] + DATA_W'(1));
    end
  end

  // Row update: old - k*hat (+ in objective column 0), truncated toward zero, then saturated
  always_comb begin
    prod_adj = prod_r + (prod_r[PROD_W-1] ? PROD_W'((1 << FRAC_BITS) - 1) : PROD_W'(0));
    m_full   = prod_adj >>> FRAC_BITS;
    m_s      = m_full[SUM_W-1:0];
    old_s    = SUM_W'(old_r);
    if (obj_mode_r && s2_col_r == '0) begin
      sum_s = old_s + m_s;
    end else if (lv_r && s2_col_r == CCNT_W'(lv_col_r)) begin
      sum_s = -m_s;
    end else begin
      sum_s = old_s - m_s;
    end
    upd_ovf = 1'b0;
    if (sum_s > SUM_W'(Q_MAX)) begin
      upd_val = Q_MAX;
      upd_ovf = 1'b1;
    end else if (sum_s < SUM_W'(Q_MIN)) begin
      upd_val = Q_MIN;
      upd_ovf = 1'b1;
    end else begin
      upd_val = sum_s[DATA_W-1:0];
    end
    if (s2_col_r == CCNT_W'(col_r)) begin
      upd_val = '0;
      upd_ovf = 1'b0;
    end
  end

  // Memory ports
  always_comb begin
    a_row   = i_r[ROW_W-1:0];
    a_col   = col_r[COL_W-1:0];
    b_row   = piv_row_r;
    b_col   = j_r[COL_W-1:0];
    o_col   = j_r[COL_W-1:0];
    tab_we  = 1'b0;
    w_row   = piv_row_r;
    w_col   = j_r[COL_W-1:0];
    w_data  = hat_val;
    obj_we  = 1'b0;
    ow_col  = s2_col_r[COL_W-1:0];
    ow_data = upd_val;
    unique case (state_r)
      S_IDLE: begin
        a_row  = in_row[ROW_W-1:0];
        a_col  = in_col[COL_W-1:0];
        o_col  = in_col[COL_W-1:0];
        w_row  = in_row[ROW_W-1:0];
        w_col  = in_col[COL_W-1:0];
        w_data = in_val;
        ow_col = in_col[COL_W-1:0];
        ow_data = in_val;
        tab_we = in_fire && in_col_ok && (action_t'(in_tuser) == ACT_LOAD_ROW);
        obj_we = in_fire && (32'(in_col) <= MAX_VARS) && (action_t'(in_tuser) == ACT_LOAD_OBJ);
      end
      S_RT_RD: begin
        b_row = i_r[ROW_W-1:0];
        b_col = '0;
      end
      S_HAT_RD: begin
        a_row  = piv_row_r;
        a_col  = j_r[COL_W-1:0];
        w_data = '0;
        tab_we = (j_r <= nv) && (j_r == CCNT_W'(col_r));
      end
      S_HAT_DIV: tab_we = div_done;
      S_OBJ_CE:  o_col = col_r[COL_W-1:0];
      S_STREAM: begin
        a_col  = j_r[COL_W-1:0];
        w_row  = i_r[ROW_W-1:0];
        w_col  = s2_col_r[COL_W-1:0];
        w_data = upd_val;
        tab_we = s2v_r && !obj_mode_r;
        obj_we = s2v_r && obj_mode_r;
      end
      S_SCAN: o_col = sc_j_r[COL_W-1:0];
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (tab_we) tab_mem[w_row][w_col] <= w_data;
    if (obj_we) obj_mem[ow_col] <= ow_data;
    tab_a_q_r <= tab_mem[a_row][a_col];
    tab_b_q_r <= tab_mem[b_row][b_col];
    obj_q_r   <= obj_mem[o_col];
  end

  // Divider
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      div_cnt_r <= '0;
    end else if (div_start) begin
      div_rem_r <= '0;
      div_num_r <= div_start_num;
      div_den_r <= div_start_den;
      div_cnt_r <= DCNT_W'(QUO_W);
    end else if (!div_done) begin
      div_rem_r <= div_ge ? (div_rem_sh - div_den_r) : div_rem_sh;
      div_num_r <= {div_num_r[QUO_W-2:0], div_ge};
      div_cnt_r <= div_cnt_r - DCNT_W'(1);
    end
  end

  // Configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      int_ratio_r <= 1'b0;
      act_rows_r  <= AROWS_W'(16);
      act_vars_r  <= AVARS_W'(32);
    end else if (cfg_wr_en) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_INT_RATIO:   int_ratio_r <= cfg_data[0];
        CFG_ACTIVE_ROWS: act_rows_r  <= cfg_data[AROWS_W-1:0];
        CFG_ACTIVE_VARS: act_vars_r  <= cfg_data[AVARS_W-1:0];
        default: ;
      endcase
    end
  end

  // Stream pipeline: stage 1 multiplies, stage 2 writes back
  always_ff @(posedge clk) begin
    prod_r   <= PROD_W'(k_r) * PROD_W'(tab_b_q_r);
    old_r    <= obj_mode_r ? obj_q_r : tab_a_q_r;
    s1_col_r <= j_r;
    s2_col_r <= s1_col_r;
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      out_tvalid_r <= 1'b0;
      s1v_r        <= 1'b0;
      s2v_r        <= 1'b0;
      sc_pend_r    <= 1'b0;
      bvalid_r     <= 1'b0;
      sat_r        <= 1'b0;
    end else begin
      if (out_tvalid_r && out_tready && state_r != S_DONE) out_tvalid_r <= 1'b0;
      s1v_r <= (state_r == S_STREAM) && (j_r <= nv);
      s2v_r <= (state_r == S_STREAM) && s1v_r;
      unique case (state_r)
        S_IDLE: begin
          if (in_fire) begin
            act_r      <= action_t'(in_tuser);
            col_r      <= in_col;
            col_ok_r   <= in_col_ok;
            rdv_r      <= '0;
            leave_r    <= '0;
            status_r   <= STAT_OK;
            sat_r      <= 1'b0;
            obj_mode_r <= 1'b0;
            lv_r       <= 1'b0;
            i_r        <= '0;
            bvalid_r   <= 1'b0;
            unique case (action_t'(in_tuser))
              ACT_SET_BASIS: begin
                if (32'(in_row) < MAX_ROWS) basis_r[in_row[ROW_W-1:0]] <= in_val[COL_F_W-1:0];
                state_r <= S_SCAN0;
              end
              ACT_PIVOT: begin
                if (in_col == '0 || CCNT_W'(in_col) > nv) begin
                  status_r <= STAT_UNBOUNDED;
                  state_r  <= S_SCAN0;
                end else begin
                  state_r <= S_RT_RD;
                end
              end
              ACT_READ_ROW, ACT_READ_OBJ: state_r <= S_RD;
              default: state_r <= S_SCAN0;
            endcase
          end
        end
        S_RD: begin
          if (act_r == ACT_READ_ROW) begin
            rdv_r <= col_ok_r ? tab_a_q_r : '0;
          end else begin
            rdv_r <= (32'(col_r) <= MAX_VARS) ? obj_q_r : '0;
          end
          state_r <= S_SCAN0;
        end
        S_RT_RD: begin
          if (i_r == nr) begin
            if (!bvalid_r) begin
              status_r <= STAT_UNBOUNDED;
              state_r  <= S_SCAN0;
            end else begin
              leave_r  <= basis_l;
              lv_col_r <= basis_l;
              lv_r     <= basis_lv;
              j_r      <= '0;
              state_r  <= S_HAT_RD;
            end
          end else begin
            state_r <= S_RT_CHK;
          end
        end
        S_RT_CHK: begin
          cand_r <= tab_a_q_r;
          if (rt_elig) begin
            state_r <= S_RT_DIV;
          end else begin
            i_r     <= i_r + RCNT_W'(1);
            state_r <= S_RT_RD;
          end
        end
        S_RT_DIV: begin
          if (div_done) begin
            if (!bvalid_r || div_num_r < best_r) begin
              piv_row_r <= i_r[ROW_W-1:0];
              piv_r     <= cand_r;
              best_r    <= q_best;
              bvalid_r  <= 1'b1;
            end
            i_r     <= i_r + RCNT_W'(1);
            state_r <= S_RT_RD;
          end
        end
        S_HAT_RD: begin
          if (j_r > nv) begin
            basis_r[piv_row_r] <= col_r;
            i_r     <= '0;
            state_r <= S_UPD_AE;
          end else if (j_r == CCNT_W'(col_r)) begin
            j_r <= j_r + CCNT_W'(1);
          end else begin
            state_r <= S_HAT_CHK;
          end
        end
        S_HAT_CHK: begin
          hat_neg_r <= hat_src[DATA_W-1];
          state_r   <= S_HAT_DIV;
        end
        S_HAT_DIV: begin
          if (div_done) begin
            if (hat_ovf) sat_r <= 1'b1;
            j_r     <= j_r + CCNT_W'(1);
            state_r <= S_HAT_RD;
          end
        end
        S_UPD_AE: begin
          if (i_r == nr) begin
            obj_mode_r <= 1'b1;
            state_r    <= S_OBJ_CE;
          end else if (i_r == RCNT_W'(piv_row_r)) begin
            i_r <= i_r + RCNT_W'(1);
          end else begin
            state_r <= S_LOAD_K;
          end
        end
        S_OBJ_CE: state_r <= S_LOAD_K;
        S_LOAD_K: begin
          k_r     <= obj_mode_r ? obj_q_r : tab_a_q_r;
          j_r     <= '0;
          state_r <= S_STREAM;
        end
        S_STREAM: begin
          if (j_r <= nv) j_r <= j_r + CCNT_W'(1);
          if (s2v_r && upd_ovf) sat_r <= 1'b1;
          // Finish the row once the last write has drained
          if (j_r > nv && !s1v_r && !s2v_r) begin
            if (obj_mode_r) begin
              state_r <= S_SCAN0;
            end else begin
              i_r     <= i_r + RCNT_W'(1);
              state_r <= S_UPD_AE;
            end
          end
        end
        S_SCAN0: begin
          sc_j_r    <= CCNT_W'(1);
          sc_pend_r <= 1'b0;
          state_r   <= S_SCAN;
        end
        S_SCAN: begin
          if (sc_pend_r && obj_q_r > 0) begin
            nxt_r     <= sc_pcol_r;
            sc_pend_r <= 1'b0;
            state_r   <= S_DONE;
          end else if (sc_j_r > nv) begin
            nxt_r     <= '0;
            sc_pend_r <= 1'b0;
            state_r   <= S_DONE;
          end else begin
            sc_pend_r <= 1'b1;
            sc_pcol_r <= sc_j_r[COL_F_W-1:0];
            sc_j_r    <= sc_j_r + CCNT_W'(1);
          end
        end
        S_DONE: begin
          // Hold until the output register is free
          if (!out_tvalid_r || out_tready) begin
            out_tvalid_r <= 1'b1;
            out_tdata_r  <= {{OUT_PAD_W{1'b0}},
                             ((status_r == STAT_OK && sat_r) ? STAT_SATURATED : status_r),
                             nxt_r, leave_r, rdv_r};
            state_r      <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule
